// ===== rtl/tolerant_float_compare_unit_defines.svh =====
// ----------------------------------------------------------------------------
// tolerant float compare: assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef TOLERANT_FLOAT_COMPARE_UNIT_DEFINES_SVH
`define TOLERANT_FLOAT_COMPARE_UNIT_DEFINES_SVH

// same-cycle implication
`define TFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfc_pkg
// shared types, order codes and helper functions of the tolerant compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfc_pkg;

  // order codes
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  localparam int unsigned NUM_STAGES = 10;

  // control that travels with each item
  typedef struct packed {
    logic        fin;     // result settled early
    logic [1:0]  res;     // early result
    logic [1:0]  cmp;     // sign of left minus right
    logic        act;     // neighborhood test still open
    logic        hood;    // neighborhood test outcome
    logic [62:0] lo_mag;  // smaller magnitude
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [62:0] big;    // larger magnitude
    logic [62:0] tol;    // tolerance magnitude
  } dec_t;

  // leading zero count over 56 bits
  function automatic logic [5:0] lzc56(input logic [55:0] x);
    logic [5:0] cnt;
    cnt = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (x[i]) begin
        cnt = 6'(55 - i);
      end
    end
    return cnt;
  endfunction

endpackage

// ===== rtl/tfc_decode.sv =====
// ----------------------------------------------------------------------------
// tfc_decode
// classifies the operand pair and settles every rule short of the
// neighborhood test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfc_decode (
  input  logic [63:0]   left_i,
  input  logic [63:0]   right_i,
  input  logic [63:0]   tol_i,
  input  logic          zero_tol_i,
  output tfc_pkg::dec_t dec_o
);

  logic        ls, rs, ts;
  logic [62:0] la, ra, tm;
  logic        lnan, rnan, tnan, tinf, tzero, lzero, rzero, lbig_inf;
  logic        mag_gt, tpos;
  logic [1:0]  cmp;
  logic [62:0] big;

  assign ls    = left_i[63];
  assign rs    = right_i[63];
  assign ts    = tol_i[63];
  assign la    = left_i[62:0];
  assign ra    = right_i[62:0];
  assign tm    = tol_i[62:0];
  assign lnan  = (la[62:52] == 11'h7ff) && (la[51:0] != 52'd0);
  assign rnan  = (ra[62:52] == 11'h7ff) && (ra[51:0] != 52'd0);
  assign tnan  = (tm[62:52] == 11'h7ff) && (tm[51:0] != 52'd0);
  assign tinf  = (tm[62:52] == 11'h7ff) && (tm[51:0] == 52'd0);
  assign tzero = (tm == 63'd0);
  assign lzero = (la == 63'd0);
  assign rzero = (ra == 63'd0);
  assign tpos  = !ts && !tnan;

  assign mag_gt   = (la > ra);
  assign big      = mag_gt ? la : ra;
  assign lbig_inf = (big[62:52] == 11'h7ff);

  // sign of the difference
  always_comb begin
    if (lnan || rnan) begin
      cmp = tfc_pkg::ORD_EQ;
    end else if (ls != rs) begin
      cmp = ls ? tfc_pkg::ORD_LT : tfc_pkg::ORD_GT;
    end else if (la == ra) begin
      cmp = tfc_pkg::ORD_EQ;
    end else begin
      cmp = (mag_gt ^ ls) ? tfc_pkg::ORD_GT : tfc_pkg::ORD_LT;
    end
  end

  // rule chain
  always_comb begin
    dec_o.ctl.fin    = 1'b1;
    dec_o.ctl.res    = tfc_pkg::ORD_EQ;
    dec_o.ctl.cmp    = cmp;
    dec_o.ctl.act    = 1'b0;
    dec_o.ctl.hood   = 1'b0;
    dec_o.ctl.lo_mag = mag_gt ? ra : la;
    dec_o.big        = big;
    dec_o.tol        = tm;
    if (lnan || rnan) begin
      dec_o.ctl.res = tfc_pkg::ORD_EQ;
    end else if ((left_i == right_i) || (lzero && rzero)) begin
      dec_o.ctl.res = tfc_pkg::ORD_EQ;
    end else if (tzero) begin
      dec_o.ctl.res = cmp;
    end else if (zero_tol_i && tpos && ((lzero && (ra <= tm)) || (rzero && (la <= tm)))) begin
      dec_o.ctl.res = tfc_pkg::ORD_EQ;
    end else if (lzero || rzero || (ls != rs)) begin
      dec_o.ctl.res = cmp;
    end else begin
      dec_o.ctl.fin = 1'b0;
      if (lbig_inf || !tpos) begin
        dec_o.ctl.hood = 1'b0;
      end else if (tinf) begin
        dec_o.ctl.hood = 1'b1;
      end else begin
        dec_o.ctl.act = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tolerant_float_compare_unit.sv =====
// path: an accepted pair passes the stage registers from decode to the output
//   register, and out_valid_o is the last stage valid bit; one pair per cycle unless stalled
// throughput: 1 item per cycle while the result channel does not stall; the
//   53x53 product is split over two multiplier stages of 27x27 partial products,
//   then sum, normalize, round, subtract, normalize and round again, one step per stage
// reset: rst_ni clears all stage valid bits and the tolerance register (+0)
// ----------------------------------------------------------------------------
// tolerant_float_compare_unit
// three-way order of two doubles under a relative tolerance register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tolerant_float_compare_unit_defines.svh"

module tolerant_float_compare_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] left_value_i,
  input  logic [63:0] right_value_i,
  input  logic        zero_tolerant_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  order_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned NS = tfc_pkg::NUM_STAGES;

  // tolerance register
  logic [63:0] tol_q;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? tol_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 64'd0;
    end else if (psel && penable && pwrite && (paddr[3] == 1'b0)) begin
      tol_q <= pwdata;
    end
  end

  // stage valid bits and enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: decode
  tfc_pkg::dec_t dec;

  tfc_decode u_decode (
    .left_i     (left_value_i),
    .right_i    (right_value_i),
    .tol_i      (tol_q),
    .zero_tol_i (zero_tolerant_i),
    .dec_o      (dec)
  );

  tfc_pkg::dec_t s1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= dec;
    end
  end

  // stage 2: normalize big and tolerance significands
  logic [52:0]        sig_b, sig_t;
  logic [5:0]         lz_b, lz_t;
  logic [10:0]        ex_b, ex_t;
  logic signed [12:0] e_b, e_t;

  assign sig_b = {s1_q.big[62:52] != 11'd0, s1_q.big[51:0]};
  assign sig_t = {s1_q.tol[62:52] != 11'd0, s1_q.tol[51:0]};
  assign lz_b  = tfc_pkg::lzc56({sig_b, 3'b111});
  assign lz_t  = tfc_pkg::lzc56({sig_t, 3'b111});
  assign ex_b  = (s1_q.big[62:52] == 11'd0) ? 11'd1 : s1_q.big[62:52];
  assign ex_t  = (s1_q.tol[62:52] == 11'd0) ? 11'd1 : s1_q.tol[62:52];
  assign e_b   = $signed({2'b00, ex_b}) - 13'sd1023 - $signed({7'd0, lz_b});
  assign e_t   = $signed({2'b00, ex_t}) - 13'sd1023 - $signed({7'd0, lz_t});

  tfc_pkg::ctl_t      s2_ctl_q;
  logic [62:0]        s2_big_q;
  logic [52:0]        s2_nb_q, s2_nt_q;
  logic signed [12:0] s2_es_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_ctl_q <= s1_q.ctl;
      s2_big_q <= s1_q.big;
      s2_nb_q  <= sig_b << lz_b;
      s2_nt_q  <= sig_t << lz_t;
      s2_es_q  <= e_b + e_t;
    end
  end

  // stage 3: low partial products
  tfc_pkg::ctl_t      s3_ctl_q;
  logic [62:0]        s3_big_q;
  logic [25:0]        s3_bl_q;
  logic [26:0]        s3_bh_q, s3_th_q;
  logic [51:0]        s3_pa_q;
  logic [52:0]        s3_pb_q;
  logic signed [12:0] s3_es_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_ctl_q <= s2_ctl_q;
      s3_big_q <= s2_big_q;
      s3_bl_q  <= s2_nb_q[25:0];
      s3_bh_q  <= s2_nb_q[52:26];
      s3_th_q  <= s2_nt_q[52:26];
      s3_pa_q  <= 52'(s2_nb_q[25:0]) * 52'(s2_nt_q[25:0]);
      s3_pb_q  <= 53'(s2_nb_q[52:26]) * 53'(s2_nt_q[25:0]);
      s3_es_q  <= s2_es_q;
    end
  end

  // stage 4: high partial products, first accumulation
  tfc_pkg::ctl_t      s4_ctl_q;
  logic [62:0]        s4_big_q;
  logic [52:0]        s4_pc_q;
  logic [53:0]        s4_pd_q;
  logic [105:0]       s4_s1_q;
  logic signed [12:0] s4_es_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_ctl_q <= s3_ctl_q;
      s4_big_q <= s3_big_q;
      s4_pc_q  <= 53'(s3_bl_q) * 53'(s3_th_q);
      s4_pd_q  <= 54'(s3_bh_q) * 54'(s3_th_q);
      s4_s1_q  <= 106'(s3_pa_q) + (106'(s3_pb_q) << 26);
      s4_es_q  <= s3_es_q;
    end
  end

  // stage 5: full product
  tfc_pkg::ctl_t      s5_ctl_q;
  logic [62:0]        s5_big_q;
  logic [105:0]       s5_p_q;
  logic signed [12:0] s5_es_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_ctl_q <= s4_ctl_q;
      s5_big_q <= s4_big_q;
      s5_p_q   <= s4_s1_q + (106'(s4_pc_q) << 26) + (106'(s4_pd_q) << 52);
      s5_es_q  <= s4_es_q;
    end
  end

  // stage 6: product normalize and subnormal denormalize
  logic [105:0]       p_n, p_m, p_mask;
  logic signed [12:0] ep, ep_under;
  logic [5:0]         p_sh;

  assign p_n      = s5_p_q[105] ? s5_p_q : (s5_p_q << 1);
  assign ep       = s5_es_q + $signed({12'd0, s5_p_q[105]});
  assign ep_under = -13'sd1022 - ep;

  always_comb begin
    if (ep_under <= 13'sd0) begin
      p_sh = 6'd0;
    end else if (ep_under > 13'sd55) begin
      p_sh = 6'd55;
    end else begin
      p_sh = ep_under[5:0];
    end
  end

  assign p_m    = p_n >> p_sh;
  assign p_mask = ~({106{1'b1}} << p_sh);

  tfc_pkg::ctl_t s6_ctl_q;
  logic [62:0]   s6_big_q;
  logic [52:0]   s6_kept_q;
  logic          s6_g_q, s6_s_q, s6_ovf_q;
  logic [11:0]   s6_ef_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_ctl_q  <= s5_ctl_q;
      s6_big_q  <= s5_big_q;
      s6_kept_q <= p_m[105:53];
      s6_g_q    <= p_m[52];
      s6_s_q    <= (|p_m[51:0]) || (|(p_n & p_mask));
      s6_ef_q   <= (ep >= -13'sd1022) ? 12'(ep + 13'sd1023) : 12'd0;
      s6_ovf_q  <= (ep > 13'sd1023);
    end
  end

  // stage 7: round the product
  logic        p_inc;
  logic [63:0] p_pat;

  assign p_inc = s6_g_q && (s6_s_q || s6_kept_q[0]);
  assign p_pat = {s6_ef_q, s6_kept_q[51:0]} + 64'(p_inc);

  tfc_pkg::ctl_t s7_ctl_q;
  logic [62:0]   s7_big_q, s7_prod_q;
  logic          s7_ovf_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_ctl_q  <= s6_ctl_q;
      s7_big_q  <= s6_big_q;
      s7_prod_q <= p_pat[62:0];
      s7_ovf_q  <= s6_ovf_q || (p_pat[63:52] >= 12'd2047);
    end
  end

  // stage 8: align and subtract product from big
  logic [10:0]   exb8, exq8, d8;
  logic [55:0]   a8, q8, q8_sh, q8_mask;
  logic          q8_st;
  logic [55:0]   bq8;
  tfc_pkg::ctl_t ctl8;

  assign exb8    = (s7_big_q[62:52] == 11'd0) ? 11'd1 : s7_big_q[62:52];
  assign exq8    = (s7_prod_q[62:52] == 11'd0) ? 11'd1 : s7_prod_q[62:52];
  assign d8      = exb8 - exq8;
  assign a8      = {s7_big_q[62:52] != 11'd0, s7_big_q[51:0], 3'b000};
  assign q8      = {s7_prod_q[62:52] != 11'd0, s7_prod_q[51:0], 3'b000};
  assign q8_sh   = q8 >> d8[5:0];
  assign q8_mask = ~({56{1'b1}} << d8[5:0]);
  assign q8_st   = |(q8 & q8_mask);

  always_comb begin
    if (d8 >= 11'd56) begin
      bq8 = {55'd0, q8 != 56'd0};
    end else begin
      bq8 = q8_sh | {55'd0, q8_st};
    end
  end

  always_comb begin
    ctl8 = s7_ctl_q;
    if (s7_ctl_q.act && (s7_ovf_q || (s7_prod_q >= s7_big_q))) begin
      ctl8.act  = 1'b0;
      ctl8.hood = 1'b1;
    end
  end

  tfc_pkg::ctl_t s8_ctl_q;
  logic [55:0]   s8_diff_q;
  logic [10:0]   s8_exb_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_ctl_q  <= ctl8;
      s8_diff_q <= a8 - bq8;
      s8_exb_q  <= exb8;
    end
  end

  // stage 9: normalize the difference
  logic [5:0]  lz9;
  logic [10:0] lim9, sh9;
  logic [55:0] n9;

  assign lz9  = tfc_pkg::lzc56(s8_diff_q);
  assign lim9 = s8_exb_q - 11'd1;
  assign sh9  = (11'(lz9) < lim9) ? 11'(lz9) : lim9;
  assign n9   = s8_diff_q << sh9[5:0];

  tfc_pkg::ctl_t s9_ctl_q;
  logic [55:0]   s9_n_q;
  logic [10:0]   s9_ef_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s9_ctl_q <= s8_ctl_q;
      s9_n_q   <= n9;
      s9_ef_q  <= n9[55] ? (s8_exb_q - sh9) : 11'd0;
    end
  end

  // stage 10: round the lower bound, compare, output register
  logic        l_inc;
  logic [62:0] low10;
  logic        hood10;
  logic [1:0]  ord10;

  assign l_inc  = s9_n_q[2] && ((|s9_n_q[1:0]) || s9_n_q[3]);
  assign low10  = {s9_ef_q, s9_n_q[54:3]} + 63'(l_inc);
  assign hood10 = s9_ctl_q.act ? (low10 <= s9_ctl_q.lo_mag) : s9_ctl_q.hood;

  always_comb begin
    if (s9_ctl_q.fin) begin
      ord10 = s9_ctl_q.res;
    end else if (hood10) begin
      ord10 = tfc_pkg::ORD_EQ;
    end else begin
      ord10 = s9_ctl_q.cmp;
    end
  end

  logic [1:0] order_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      order_q <= ord10;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign order_o     = order_q;

  // checks
  `TFC_ASSERT_NOW(a_full_stall, (&v_q) && !out_ready_i, !in_ready_o, "full pipe did not stall")
  `TFC_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, v_q[0], "accepted item lost at entry")
  `TFC_ASSERT_NOW(a_code, out_valid_o, order_o != 2'b10, "illegal order code")

endmodule

// ===== test/tb_tolerant_float_compare_unit.sv =====
// ----------------------------------------------------------------------------
// tb_tolerant_float_compare_unit
// Drives pairs of double bit patterns, with the zero-test flag, into the
// tolerant compare unit under several tolerance settings. Typed table rows carry
// their own order, a real-valued predictor works out the order of every other pair,
// and every result transfer is checked in order against these. Both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tolerant_float_compare_unit;

  localparam int unsigned DRAIN_CYCLES = tfc_pkg::NUM_STAGES + 4;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS  = 85;
  localparam logic [3:0]  ADDR_TOL     = 4'd0;

  // tolerance settings walked by the random part
  localparam int unsigned NUM_TOLS = 11;
  localparam logic [63:0] TOL_SET [NUM_TOLS] = '{
    64'h0000_0000_0000_0000,  // exact compare
    64'h3D06_849B_86A1_2B9B,  // 1e-14 range, typical
    64'h3EB0_C6F7_A0B5_ED8D,  // 1e-6
    64'h3FE0_0000_0000_0000,  // 0.5
    64'h3FF0_0000_0000_0000,  // 1.0
    64'hBFB9_9999_9999_999A,  // negative tolerance
    64'h8000_0000_0000_0000,  // -0
    64'h7FF0_0000_0000_0000,  // infinity
    64'hFFFF_FFFF_FFFF_FFFF,  // all ones, NaN
    64'h0000_0000_0000_0001,  // smallest subnormal
    64'h7FEF_FFFF_FFFF_FFFF   // largest finite
  };

  typedef struct packed {
    logic [63:0] tol;
    logic [63:0] left;
    logic [63:0] right;
    logic        zt;
    logic        typed;
    logic [1:0]  order;
  } vec_t;

  // directed table: tolerance, left, right, zero test, typed, order
  localparam int unsigned NUM_VECS = 22;
  localparam vec_t VECS [NUM_VECS] = '{
    '{64'h0, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 1'b1,
      tfc_pkg::ORD_EQ},
    '{64'h0, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, 1'b1,
      tfc_pkg::ORD_LT},
    '{64'h0, 64'h4000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1, 1'b1,
      tfc_pkg::ORD_GT},
    '{64'h0, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b0, 1'b1,
      tfc_pkg::ORD_LT},
    '{64'h0, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b0, 1'b1,
      tfc_pkg::ORD_EQ},
    '{64'h0, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
      tfc_pkg::ORD_EQ},
    '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
      tfc_pkg::ORD_EQ},
    '{64'h0, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
      tfc_pkg::ORD_GT},
    '{64'h0, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
      tfc_pkg::ORD_GT},
    // tolerance 0.5: neighborhood, zero test, sign rules
    '{64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FE3_3333_3333_3333,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FD9_9999_9999_999A,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h3FD3_3333_3333_3333,
      1'b1, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h3FD3_3333_3333_3333,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'hBFE6_6666_6666_6666, 64'h8000_0000_0000_0000,
      1'b1, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'hBFE6_6666_6666_6666,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'h7FE0_0000_0000_0000,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3FE0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000,
      1'b1, 1'b0, tfc_pkg::ORD_EQ},
    // negative tolerance and tiny tolerance
    '{64'hBFE0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3CB0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF,
      1'b0, 1'b0, tfc_pkg::ORD_EQ},
    '{64'h3CB0_0000_0000_0000, 64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000,
      1'b1, 1'b0, tfc_pkg::ORD_EQ}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] left_value_i = '0;
  logic [63:0] right_value_i = '0;
  logic        zero_tolerant_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  order_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic [1:0]  order_queue [$];
  logic [63:0] cur_tol = '0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_hold = 0;
  logic        ready_steady = 1'b0;

  tolerant_float_compare_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_value_i   (left_value_i),
    .right_value_i  (right_value_i),
    .zero_tolerant_i(zero_tolerant_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .order_o        (order_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sign of a real, zero for zeros and NaN
  function automatic int real_sign(input real x);
    if (x > 0.0) return 1;
    if (x < 0.0) return -1;
    return 0;
  endfunction

  function automatic logic [1:0] sign_code(input int s);
    if (s > 0) return tfc_pkg::ORD_GT;
    if (s < 0) return tfc_pkg::ORD_LT;
    return tfc_pkg::ORD_EQ;
  endfunction

  // small in [big - big*tol, big), each step rounded on its own
  function automatic bit within_hood(input real lo_mag, input real hi_mag, input real tol);
    real prod;
    real low;
    prod = hi_mag * tol;
    low  = hi_mag - prod;
    return (low <= lo_mag) && (lo_mag < hi_mag);
  endfunction

  // expected order of one pair under the given tolerance
  function automatic logic [1:0] tolerant_order(input logic [63:0] lb, input logic [63:0] rb,
                                                input logic [63:0] tb, input logic zt);
    real l;
    real r;
    real t;
    real la;
    real ra;
    int  diff_sign;
    l = $bitstoreal(lb);
    r = $bitstoreal(rb);
    t = $bitstoreal(tb);
    if (lb == rb || l == r) return tfc_pkg::ORD_EQ;
    diff_sign = real_sign(l - r);
    if (t == 0.0) return sign_code(diff_sign);
    la = (l < 0.0) ? -l : l;
    ra = (r < 0.0) ? -r : r;
    if (zt) begin
      if (l == 0.0 && ra <= t) return tfc_pkg::ORD_EQ;
      if (r == 0.0 && la <= t) return tfc_pkg::ORD_EQ;
    end
    if (real_sign(l) != real_sign(r)) return sign_code(diff_sign);
    if (within_hood(la, ra, t) || within_hood(ra, la, t)) return tfc_pkg::ORD_EQ;
    return sign_code(diff_sign);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len(input bit steady);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // operand shaped around another value and the tolerance
  function automatic logic [63:0] shaped_operand(input logic [63:0] other, input logic [63:0] tb);
    real base;
    real t;
    real frac;
    logic [63:0] v;
    base = $bitstoreal(other);
    t    = $bitstoreal(tb);
    frac = $urandom_range(0, 2000) / 1000.0;
    case ($urandom_range(0, 11))
      0, 1:    v = {$urandom, $urandom};
      2:       v = {1'($urandom), 63'd0};
      3: begin
        case ($urandom_range(0, 4))
          0:       v = 64'h7FF0_0000_0000_0000;
          1:       v = 64'h7FEF_FFFF_FFFF_FFFF;
          2:       v = 64'h0000_0000_0000_0001;
          3:       v = 64'h0010_0000_0000_0000;
          default: v = 64'h7FF8_0000_0000_0001;
        endcase
        v[63] = 1'($urandom);
      end
      4, 5:    v = $realtobits(base * (1.0 - t * frac));
      6:       v = $realtobits(base * (1.0 + t * frac));
      7:       v = $realtobits(base - base * t);
      8:       v = other + 64'($urandom_range(0, 8)) - 64'd4;
      9:       v = $realtobits(t * frac);
      10:      v = {~other[63], other[62:0]};
      default: v = other;
    endcase
    if ($urandom_range(0, 9) == 0) v[63] = ~v[63];
    return v;
  endfunction

  task automatic drain_results();
    while (order_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write: setup then access cycle
  task automatic write_tolerance(input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TOL;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_tol = value;
  endtask

  // one input transfer; predicted order is queued at acceptance
  task automatic send_pair(input logic [63:0] lv, input logic [63:0] rv, input logic zt,
                           input logic typed, input logic [1:0] typed_order, input bit steady);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    left_value_i    <= lv;
    right_value_i   <= rv;
    zero_tolerant_i <= zt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    order_queue.push_back(typed ? typed_order : tolerant_order(lv, rv, cur_tol, zt));
    gap = gap_len(steady);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: check, random stalls, watchdog
  always @(posedge clk_i) begin
    logic [1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (order_queue.size() == 0) begin
        $error("order: result with no expectation, actual %0d", order_o);
        fail_count++;
      end else begin
        want = order_queue.pop_front();
        if (order_o !== want) begin
          $error("order mismatch: expected %0d actual %0d", want, order_o);
          fail_count++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (ready_hold != 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      ready_hold  <= gap_len(ready_steady);
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    logic [63:0] lv;
    logic [63:0] rv;
    logic        zt;
    logic        first;
    bit          steady;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, tolerance changed only while idle
    foreach (VECS[i]) begin
      if (VECS[i].tol !== cur_tol) begin
        idle_input();
        drain_results();
        write_tolerance(VECS[i].tol);
      end
      send_pair(VECS[i].left, VECS[i].right, VECS[i].zt, VECS[i].typed, VECS[i].order, 1'b0);
    end

    // random phases over the tolerance set, then random patterns
    for (int p = 0; p < NUM_TOLS + 2; p++) begin
      idle_input();
      drain_results();
      write_tolerance(p < NUM_TOLS ? TOL_SET[p] : {$urandom, $urandom});
      steady       = (p % 4 == 1);
      ready_steady = (p % 4 == 2);
      for (int n = 0; n < PHASE_ITEMS * 10 / (NUM_TOLS + 2); n++) begin
        first = $urandom_range(0, 1);
        lv = shaped_operand({$urandom, $urandom}, cur_tol);
        rv = shaped_operand(lv, cur_tol);
        zt = 1'($urandom);
        if (first) send_pair(lv, rv, zt, 1'b0, tfc_pkg::ORD_EQ, steady);
        else       send_pair(rv, lv, zt, 1'b0, tfc_pkg::ORD_EQ, steady);
      end
    end
    idle_input();

    while (order_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tfc_pkg.sv
rtl/tfc_decode.sv
rtl/tolerant_float_compare_unit.sv
test/tb_tolerant_float_compare_unit.sv
